// ----- hw/rtl/log_ring_with_crlf_tx_top_macros.svh -----
// Assertion macros used by the log ring datapath.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef LOG_RING_WITH_CRLF_TX_TOP_MACROS_SVH
`define LOG_RING_WITH_CRLF_TX_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LRCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LRCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lrct_pkg.sv -----
// Shared types and constants for the log ring with CR/LF transmit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrct_pkg;

    localparam int READ_W = 7;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_LOG   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [7:0]        char_in;
        logic [READ_W-1:0] read_limit;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data_byte;
        logic [READ_W-1:0] read_count;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WR_CHAR,
        ST_RD_RUN
    } ctl_state_t;

    typedef struct packed {
        logic load_read;
        logic load_char;
        logic emit_cr;
        logic emit_in;
        logic emit_held;
        logic read_step;
        logic emit_empty;
    } dp_cmd_t;

    typedef struct packed {
        logic port_en;
        logic in_is_lf;
        logic remain_zero;
        logic remain_last;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrct_ctrl.sv -----
// Controller state machine for the log ring block.
// Depends on lrct_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps
`default_nettype none

module lrct_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             operation,
    input  wire lrct_pkg::dp_sts_t sts,
    output logic                  busy,
    output lrct_pkg::dp_cmd_t     cmd
);
    import lrct_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_READ)
                    begin
                        state_next = ST_RD_RUN;
                    end
                    else if (sts.port_en && sts.in_is_lf)
                    begin
                        state_next = ST_WR_CHAR;
                    end
                end
            end
            ST_WR_CHAR:
            begin
                state_next = ST_IDLE;
            end
            ST_RD_RUN:
            begin
                if (sts.remain_zero || sts.remain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_READ)
                    begin
                        cmd.load_read = 1'b1;
                    end
                    else if (sts.port_en)
                    begin
                        if (sts.in_is_lf)
                        begin
                            cmd.emit_cr   = 1'b1;
                            cmd.load_char = 1'b1;
                        end
                        else
                        begin
                            cmd.emit_in = 1'b1;
                        end
                    end
                end
            end
            ST_WR_CHAR:
            begin
                cmd.emit_held = 1'b1;
            end
            ST_RD_RUN:
            begin
                if (sts.remain_zero)
                begin
                    cmd.emit_empty = 1'b1;
                end
                else
                begin
                    cmd.read_step = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lrct_dp.sv -----
// Datapath for the log ring: log memory, pointers, fill count, result register.
// Depends on lrct_pkg and the assertion macro header; driven by lrct_ctrl.
`timescale 1ns / 1ps
`default_nettype none

`include "log_ring_with_crlf_tx_top_macros.svh"

module lrct_dp #(
    parameter int LOG_DEPTH = 4096,
    parameter int MAX_READ  = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lrct_pkg::cmd_item_t item,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire lrct_pkg::dp_cmd_t   cmd,
    output lrct_pkg::dp_sts_t        sts,
    output lrct_pkg::result_t        result,
    output logic                     result_valid
);
    import lrct_pkg::*;

    localparam int AW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int FW   = $clog2(LOG_DEPTH + 1);
    localparam int CMPW = (FW > READ_W) ? FW : READ_W;

    logic [7:0] log_mem [LOG_DEPTH];
    logic [7:0] mem_q_reg;

    logic              port_en_reg;
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [FW-1:0]     fill_reg;
    logic [READ_W-1:0] count_reg;
    logic [READ_W-1:0] remain_reg;
    logic [7:0]        held_reg;

    logic              res_valid_reg;
    logic [1:0]        res_kind_reg;
    logic [7:0]        res_byte_reg;
    logic              res_from_mem_reg;
    logic [READ_W-1:0] res_count_reg;
    logic              res_last_reg;

    logic [READ_W-1:0] lim_sat;
    logic [READ_W-1:0] avail;
    logic [7:0]        wr_char;
    logic              do_log;
    logic              full;
    logic [AW-1:0]     wr_ptr_inc;
    logic [AW-1:0]     rd_ptr_inc;

    always_comb
    begin
        lim_sat = (item.read_limit > READ_W'(MAX_READ)) ? READ_W'(MAX_READ)
                                                        : item.read_limit;
        avail   = (CMPW'(fill_reg) > CMPW'(lim_sat)) ? lim_sat : READ_W'(fill_reg);
        wr_char = cmd.emit_held ? held_reg : item.char_in;
        do_log  = (cmd.emit_in || cmd.emit_held) && (wr_char != CH_CR);
        full    = (fill_reg == FW'(LOG_DEPTH));
        wr_ptr_inc = (wr_ptr_reg == AW'(LOG_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_inc = (rd_ptr_reg == AW'(LOG_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    always_comb
    begin
        sts.port_en     = port_en_reg;
        sts.in_is_lf    = (item.char_in == CH_LF);
        sts.remain_zero = (remain_reg == '0);
        sts.remain_last = (remain_reg == READ_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (do_log)
        begin
            log_mem[wr_ptr_reg] <= wr_char;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_step)
        begin
            mem_q_reg <= log_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_en_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                port_en_reg <= cfg_wdata;
            end
            if (cmd.load_read)
            begin
                remain_reg <= avail;
            end
            if (do_log)
            begin
                wr_ptr_reg <= wr_ptr_inc;
                if (full)
                begin
                    rd_ptr_reg <= rd_ptr_inc;
                end
                else
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (cmd.read_step)
            begin
                rd_ptr_reg <= rd_ptr_inc;
                fill_reg   <= fill_reg - 1'b1;
                remain_reg <= remain_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_read)
        begin
            count_reg <= avail;
        end
        if (cmd.load_char)
        begin
            held_reg <= item.char_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.emit_cr || cmd.emit_in || cmd.emit_held
                             || cmd.read_step || cmd.emit_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_cr)
        begin
            res_kind_reg     <= KIND_TX;
            res_byte_reg     <= CH_CR;
            res_from_mem_reg <= 1'b0;
            res_count_reg    <= '0;
            res_last_reg     <= 1'b0;
        end
        else if (cmd.emit_in || cmd.emit_held)
        begin
            res_kind_reg     <= KIND_TX;
            res_byte_reg     <= wr_char;
            res_from_mem_reg <= 1'b0;
            res_count_reg    <= '0;
            res_last_reg     <= 1'b1;
        end
        else if (cmd.read_step)
        begin
            res_kind_reg     <= KIND_LOG;
            res_byte_reg     <= '0;
            res_from_mem_reg <= 1'b1;
            res_count_reg    <= count_reg;
            res_last_reg     <= (remain_reg == READ_W'(1));
        end
        else if (cmd.emit_empty)
        begin
            res_kind_reg     <= KIND_EMPTY;
            res_byte_reg     <= '0;
            res_from_mem_reg <= 1'b0;
            res_count_reg    <= '0;
            res_last_reg     <= 1'b1;
        end
    end

    always_comb
    begin
        result_valid      = res_valid_reg;
        result.kind       = res_kind_reg;
        result.data_byte  = res_from_mem_reg ? mem_q_reg : res_byte_reg;
        result.read_count = res_count_reg;
        result.last       = res_last_reg;
    end

    `LRCT_ASSERT_IMP(a_step_has_remain, cmd.read_step, remain_reg != '0, "read past count")
    `LRCT_ASSERT_IMP(a_step_has_fill, cmd.read_step, fill_reg != '0, "read from empty log")
    `LRCT_ASSERT_IMP(a_empty_no_remain, cmd.emit_empty, remain_reg == '0, "empty with data left")
    `LRCT_ASSERT_NXT(a_step_gives_log, cmd.read_step, result_valid && result.kind == KIND_LOG, "read step lost")
    `LRCT_ASSERT_NXT(a_full_stays_full, do_log && full, $stable(fill_reg), "full log count moved")

endmodule

`default_nettype wire

// ----- hw/rtl/log_ring_with_crlf_tx_top.sv -----
// Log ring with CR/LF transmit: top level joining controller and datapath.
// Depends on lrct_pkg, lrct_ctrl and lrct_dp.
//
// Usage:
//   Command channel: present cmd and raise start; the item transfers at a
//   rising edge where start is high and busy is low.
//   Result channel: each result sits on result for one cycle with
//   result_valid high; the receiver cannot stall, so it must take it then.
//   Config: cfg_we with cfg_wdata sets the port enable; write only while idle.
// Sequences:
//   Write: first result in the cycle after the transfer. A line feed gives a
//   carriage return then the line feed (busy while the line feed is sent);
//   other characters give one result. Disabled writes give nothing.
//   Read: the read is sized at the transfer, then one stored byte per cycle
//   comes from the single log memory read port; an empty read gives a
//   single empty result. Each result follows its step in the next cycle.
// Reset: log emptied, pointers cleared, port disabled; memory contents
//   are left as they are and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

module log_ring_with_crlf_tx_top #(
    parameter int LOG_DEPTH = 4096,
    parameter int MAX_READ  = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire lrct_pkg::cmd_item_t cmd,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    output lrct_pkg::result_t        result,
    output logic                     result_valid
);
    import lrct_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    lrct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (cmd.operation),
        .sts       (dp_sts),
        .busy      (busy),
        .cmd       (dp_cmd)
    );

    lrct_dp #(
        .LOG_DEPTH (LOG_DEPTH),
        .MAX_READ  (MAX_READ)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire
